>>> src/temperature_to_bcd_display_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the temperature to BCD display block
// Concurrent assertion wrappers that are compiled away for synthesis.
// ---------------------------------------------------------------------------
`ifndef TEMPERATURE_TO_BCD_DISPLAY_ASSERT_SVH
`define TEMPERATURE_TO_BCD_DISPLAY_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset.
`define TBCD_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("temperature_to_bcd_display: assertion failed");

// Checked on every rising edge, reset included.
`define TBCD_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) \
    else $error("temperature_to_bcd_display: reset assertion failed");

`else

`define TBCD_ASSERT(lbl, clk_s, rstn_s, prop)
`define TBCD_ASSERT_ALWAYS(lbl, clk_s, prop)

`endif

`endif

>>> src/tbcd_pkg.sv
// ---------------------------------------------------------------------------
// Temperature to BCD display package
// Widths, scaling constants and the display record shared by the modules.
// ---------------------------------------------------------------------------
package tbcd_pkg;

  localparam int RAW_W   = 16;  // sensor reading width
  localparam int NUM_W   = 22;  // signed hundredths times 32
  localparam int VALUE_W = 16;  // magnitude in hundredths of a degree
  localparam int DIGIT_W = 4;
  localparam int FRAC_SHIFT = 5;  // divide by 32

  // Hundredths times 32: Celsius raw*25, Fahrenheit raw*45 + 32*100*32.
  localparam logic signed [NUM_W-1:0] C_MULT   = 22'sd25;
  localparam logic signed [NUM_W-1:0] F_MULT   = 22'sd45;
  localparam logic signed [NUM_W-1:0] F_OFFSET = 22'sd102400;

  localparam logic [VALUE_W-1:0] BLANK_LIMIT = 16'd1000;

  typedef struct packed {
    logic                  tens_blank;
    logic [DIGIT_W-1:0]    tens;
    logic [DIGIT_W-1:0]    ones;
    logic [DIGIT_W-1:0]    tenths;
    logic [DIGIT_W-1:0]    hundredths;
    logic                  unit_is_f;
  } disp_t;

endpackage

>>> src/tbcd_scale.sv
// ---------------------------------------------------------------------------
// Temperature scaling
// Converts a raw reading to the magnitude in hundredths of a degree.
// ---------------------------------------------------------------------------
module tbcd_scale
  import tbcd_pkg::*;
(
  input  logic signed [RAW_W-1:0]   raw_temp,
  input  logic                      fahrenheit,
  output logic        [VALUE_W-1:0] value
);

  logic signed [NUM_W-1:0] raw_ext;
  logic signed [NUM_W-1:0] num;
  logic        [NUM_W-1:0] mag;

  always_comb begin
    raw_ext = $signed({{(NUM_W-RAW_W){raw_temp[RAW_W-1]}}, raw_temp});
    if (fahrenheit) begin
      num = raw_ext * F_MULT + F_OFFSET;
    end else begin
      num = raw_ext * C_MULT;
    end
    // Truncation toward zero: divide the magnitude, not the signed value.
    mag   = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
    value = mag[FRAC_SHIFT +: VALUE_W];
  end

endmodule

>>> src/tbcd_digits.sv
// ---------------------------------------------------------------------------
// Decimal digit split
// Splits the magnitude into four decimal digits with tens blanking.
// ---------------------------------------------------------------------------
module tbcd_digits
  import tbcd_pkg::*;
(
  input  logic [VALUE_W-1:0] value,
  input  logic               unit_is_f,
  output disp_t              disp
);

  localparam int PROD_W = 48;

  // Reciprocals are exact for every magnitude the scaling can produce.
  localparam logic [PROD_W-1:0] RECIP_10    = 48'd52429;
  localparam int                SHIFT_10    = 19;
  localparam logic [PROD_W-1:0] RECIP_100   = 48'd83887;
  localparam int                SHIFT_100   = 23;
  localparam logic [PROD_W-1:0] RECIP_1000  = 48'd67109;
  localparam int                SHIFT_1000  = 26;
  localparam logic [PROD_W-1:0] RECIP_10000 = 48'd53688;
  localparam int                SHIFT_10000 = 29;

  localparam logic [VALUE_W-1:0] TEN = 16'd10;

  function automatic logic [VALUE_W-1:0] div_const(input logic [VALUE_W-1:0] v,
                                                   input logic [PROD_W-1:0] recip,
                                                   input int shift);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(v) * recip;
    return prod[shift +: VALUE_W];
  endfunction

  logic [VALUE_W-1:0] q1, q2, q3, q4;
  logic [VALUE_W-1:0] r0, r1, r2, r3;

  always_comb begin
    q1 = div_const(value, RECIP_10, SHIFT_10);
    q2 = div_const(value, RECIP_100, SHIFT_100);
    q3 = div_const(value, RECIP_1000, SHIFT_1000);
    q4 = div_const(value, RECIP_10000, SHIFT_10000);
    r0 = value - q1 * TEN;
    r1 = q1 - q2 * TEN;
    r2 = q2 - q3 * TEN;
    r3 = q3 - q4 * TEN;

    disp.unit_is_f  = unit_is_f;
    disp.hundredths = r0[DIGIT_W-1:0];
    disp.tenths     = r1[DIGIT_W-1:0];
    disp.ones       = r2[DIGIT_W-1:0];
    disp.tens       = r3[DIGIT_W-1:0];
    disp.tens_blank = (value < BLANK_LIMIT);
  end

endmodule

>>> src/temperature_to_bcd_display.sv
// ---------------------------------------------------------------------------
// Temperature to BCD display
// Turns sensor readings into four display digits, a unit and tens blanking.
// ---------------------------------------------------------------------------
// Each input item carries a read status, a signed reading at 128 counts per
// degree Celsius and a Fahrenheit select. Each item yields exactly one result
// item: the unit flag, the tens, ones, tenths and hundredths digits of the
// absolute temperature in hundredths of a degree, and a tens blank flag.
// An item whose read failed repeats the previous display unchanged.
// Both channels use valid and stall; an item moves at a rising edge where
// valid is high and stall is low.
// The input register captures the item at the accepting edge, the scaling
// multiply and the reciprocal digit split follow, and the result register
// captures the display when the result stage moves. Throughput is one
// item per cycle while the receiver does not stall, set by the single
// pass of logic between the two registers.
// When the receiver stalls, the result register holds; the input register
// still takes one more item if it is empty, and only then is in_stall raised.
// A synchronous active-low reset empties both stages and sets the shown
// display to all zeros: unit C, all digits 0, tens not blanked.
// ---------------------------------------------------------------------------
`include "temperature_to_bcd_display_assert.svh"

module temperature_to_bcd_display
  import tbcd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_read_ok,
  input  logic signed [RAW_W-1:0]   in_raw_temp,
  input  logic                      in_fahrenheit,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_unit_is_f,
  output logic        [DIGIT_W-1:0] out_digit_hundredths,
  output logic        [DIGIT_W-1:0] out_digit_tenths,
  output logic        [DIGIT_W-1:0] out_digit_ones,
  output logic        [DIGIT_W-1:0] out_digit_tens,
  output logic                      out_tens_blank
);

  // Input stage.
  logic                    s1_valid_r;
  logic                    s1_read_ok_r;
  logic signed [RAW_W-1:0] s1_raw_r;
  logic                    s1_fahrenheit_r;

  // Result stage. The result register doubles as the remembered display,
  // so a failed read simply leaves it as it is.
  logic  out_valid_r;
  disp_t out_disp_r;
  disp_t out_disp_nxt;

  logic               adv_out;
  logic               adv_s1;
  logic [VALUE_W-1:0] value;
  disp_t              new_disp;

  // The result stage moves when it is empty or its item is being taken;
  // the input stage moves when it is empty or can hand its item on.
  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_s1   = !s1_valid_r || adv_out;
  assign in_stall = !adv_s1;

  tbcd_scale u_scale (
    .raw_temp   (s1_raw_r),
    .fahrenheit (s1_fahrenheit_r),
    .value      (value)
  );

  tbcd_digits u_digits (
    .value     (value),
    .unit_is_f (s1_fahrenheit_r),
    .disp      (new_disp)
  );

  always_comb begin
    out_disp_nxt = out_disp_r;
    if (adv_out && s1_valid_r && s1_read_ok_r) begin
      out_disp_nxt = new_disp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_disp_r  <= '0;
    end else begin
      if (adv_s1) begin
        s1_valid_r <= in_valid;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
      out_disp_r <= out_disp_nxt;
    end
  end

  // Payload of the input stage needs no reset.
  always_ff @(posedge clk) begin
    if (adv_s1 && in_valid) begin
      s1_read_ok_r    <= in_read_ok;
      s1_raw_r        <= in_raw_temp;
      s1_fahrenheit_r <= in_fahrenheit;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_unit_is_f        = out_disp_r.unit_is_f;
  assign out_digit_hundredths = out_disp_r.hundredths;
  assign out_digit_tenths     = out_disp_r.tenths;
  assign out_digit_ones       = out_disp_r.ones;
  assign out_digit_tens       = out_disp_r.tens;
  assign out_tens_blank       = out_disp_r.tens_blank;

  // An accepted item always lands in the input stage.
  `TBCD_ASSERT(a_accept_fills_s1, clk, rst_n, (in_valid && !in_stall) |=> s1_valid_r)
  // A failed read moving on leaves the shown display untouched.
  `TBCD_ASSERT(a_failed_read_holds, clk, rst_n,
    (adv_out && s1_valid_r && !s1_read_ok_r) |=> $stable(out_disp_r))
  // Every offered digit is a decimal digit.
  `TBCD_ASSERT(a_digits_decimal, clk, rst_n,
    out_valid_r |-> (out_disp_r.hundredths <= 4'd9 && out_disp_r.tenths <= 4'd9 &&
                     out_disp_r.ones <= 4'd9 && out_disp_r.tens <= 4'd9))
  // A blanked tens position only ever covers a zero digit.
  `TBCD_ASSERT(a_blank_means_zero, clk, rst_n, out_disp_r.tens_blank |-> (out_disp_r.tens == 4'd0))
  // Reset empties both stages.
  `TBCD_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> (!s1_valid_r && !out_valid_r))

endmodule

>>> dv/temperature_display_checker.sv
// ---------------------------------------------------------------------------
// Temperature display checker
// Watches both channels, predicts every display item and compares it.
// ---------------------------------------------------------------------------
module temperature_display_checker
  import tbcd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_read_ok,
  input  logic signed [RAW_W-1:0]   in_raw_temp,
  input  logic                      in_fahrenheit,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_unit_is_f,
  input  logic        [DIGIT_W-1:0] out_digit_hundredths,
  input  logic        [DIGIT_W-1:0] out_digit_tenths,
  input  logic        [DIGIT_W-1:0] out_digit_ones,
  input  logic        [DIGIT_W-1:0] out_digit_tens,
  input  logic                      out_tens_blank,
  output int                        mismatches,
  output int                        pending_results
);

  // The shown display is cleared by the reset that opens every run.
  disp_t shown_display;
  disp_t expected_displays[$];
  int    error_count;

  // Hundredths of a degree, truncated toward zero, then split into digits.
  function automatic disp_t scale_reading(input logic signed [RAW_W-1:0] raw,
                                          input logic to_f);
    int    scaled;
    int    value;
    disp_t d;
    scaled = to_f ? (int'(raw) * 45 + 102400) : (int'(raw) * 25);
    value  = ((scaled < 0) ? -scaled : scaled) / 32;
    d.unit_is_f  = to_f;
    d.hundredths = DIGIT_W'(value % 10);
    d.tenths     = DIGIT_W'((value / 10) % 10);
    d.ones       = DIGIT_W'((value / 100) % 10);
    d.tens       = DIGIT_W'((value / 1000) % 10);
    d.tens_blank = (value < 1000);
    return d;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    disp_t want;
    if (!rst_n) begin
      shown_display = '0;
      expected_displays.delete();
    end else begin
      if (in_valid && !in_stall) begin
        // A failed read leaves the shown display as it is.
        if (in_read_ok)
          shown_display = scale_reading(in_raw_temp, in_fahrenheit);
        expected_displays.push_back(shown_display);
      end
      if (out_valid && !out_stall) begin
        if (expected_displays.size() == 0) begin
          $error("result item arrived with no display expected");
          error_count++;
        end else begin
          want = expected_displays.pop_front();
          check_field("unit_is_f", want.unit_is_f, out_unit_is_f);
          check_field("digit_hundredths", want.hundredths, out_digit_hundredths);
          check_field("digit_tenths", want.tenths, out_digit_tenths);
          check_field("digit_ones", want.ones, out_digit_ones);
          check_field("digit_tens", want.tens, out_digit_tens);
          check_field("tens_blank", want.tens_blank, out_tens_blank);
        end
      end
    end
    mismatches      <= error_count;
    pending_results <= expected_displays.size();
  end

endmodule

>>> dv/tb_temperature_to_bcd_display.sv
// ---------------------------------------------------------------------------
// Temperature to BCD display testbench
// Drives sensor readings into the block and lets the checker judge results.
// ---------------------------------------------------------------------------
// The top generates the clock and reset, offers reading items on the input
// channel and stalls the result channel at random. A checker instance beside
// the block predicts every display item and counts mismatches; the top only
// gives the verdict. A directed opening covers the reset display, failed
// reads, both units, the extremes of the reading, tens blanking at its
// boundary, negative values and dropped upper digits. Random items follow,
// with one long receiver hold-off, one sender pause until the block drains
// and one stretch with no idling on either side.
// ---------------------------------------------------------------------------
module tb_temperature_to_bcd_display
  import tbcd_pkg::*;
();

  // Cycles without any accepted item before the run is abandoned. The
  // longest legitimate quiet spell is the receiver hold-off.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 10;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_read_ok = 1'b0;
  logic signed [RAW_W-1:0]   in_raw_temp = '0;
  logic                      in_fahrenheit = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_unit_is_f;
  logic        [DIGIT_W-1:0] out_digit_hundredths;
  logic        [DIGIT_W-1:0] out_digit_tenths;
  logic        [DIGIT_W-1:0] out_digit_ones;
  logic        [DIGIT_W-1:0] out_digit_tens;
  logic                      out_tens_blank;

  int mismatches;
  int pending_results;
  int quiet_cycles = 0;

  // When set, neither side idles. The hold request asks the receiver for
  // one long stall; the receiver clears it once the stall is over.
  bit no_idling = 1'b0;
  bit hold_request = 1'b0;

  always #10 clk = ~clk;

  temperature_to_bcd_display DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_read_ok           (in_read_ok),
    .in_raw_temp          (in_raw_temp),
    .in_fahrenheit        (in_fahrenheit),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_unit_is_f        (out_unit_is_f),
    .out_digit_hundredths (out_digit_hundredths),
    .out_digit_tenths     (out_digit_tenths),
    .out_digit_ones       (out_digit_ones),
    .out_digit_tens       (out_digit_tens),
    .out_tens_blank       (out_tens_blank)
  );

  temperature_display_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_read_ok           (in_read_ok),
    .in_raw_temp          (in_raw_temp),
    .in_fahrenheit        (in_fahrenheit),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_unit_is_f        (out_unit_is_f),
    .out_digit_hundredths (out_digit_hundredths),
    .out_digit_tenths     (out_digit_tenths),
    .out_digit_ones       (out_digit_ones),
    .out_digit_tens       (out_digit_tens),
    .out_tens_blank       (out_tens_blank),
    .mismatches           (mismatches),
    .pending_results      (pending_results)
  );

  // Offers one reading item and returns at the edge where it is accepted.
  // Random idle cycles may come first; each one lowers valid at its own edge,
  // so valid is never lowered and raised again within one time step.
  task automatic offer_reading(input bit ok, input logic signed [RAW_W-1:0] raw,
                               input bit to_f);
    if (!no_idling) begin
      while ($urandom_range(0, 99) < 12) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_read_ok    <= ok;
    in_raw_temp   <= raw;
    in_fahrenheit <= to_f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // The sender stops and waits until every expected display item has come.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Readings are drawn from the whole 16-bit range, from a plausible sensor
  // range of -40 to +150 degrees, and from around the tens blanking edge.
  function automatic logic signed [RAW_W-1:0] random_reading();
    int pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0, 1: random_reading = RAW_W'($urandom);
      2: random_reading = RAW_W'(int'($urandom_range(0, 190 * 128)) - 40 * 128);
      default: random_reading = RAW_W'(int'($urandom_range(0, 40)) - 20 +
                                       ($urandom_range(0, 1) ? 1280 : -1280));
    endcase
  endfunction

  task automatic offer_random_readings(input int count);
    int n;
    for (n = 0; n < count; n++)
      offer_reading($urandom_range(0, 99) < 85, random_reading(),
                    1'($urandom_range(0, 1)));
  endtask

  // Receiver: random stalls, none while no_idling is set, and one long
  // hold-off on request, counted here in cycles.
  initial begin
    int k;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !no_idling && ($urandom_range(0, 99) < 12);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A failed read before any good read shows the all-zero reset display,
    // whatever the unit select says.
    offer_reading(1'b0, 16'sd1234, 1'b1);
    offer_reading(1'b0, -16'sd1, 1'b0);

    // Zero, plus and minus one count, and one degree either side of zero.
    offer_reading(1'b1, 16'sd0, 1'b0);
    offer_reading(1'b1, 16'sd0, 1'b1);
    offer_reading(1'b1, 16'sd1, 1'b0);
    offer_reading(1'b1, -16'sd1, 1'b0);
    offer_reading(1'b1, 16'sd128, 1'b1);
    offer_reading(1'b1, -16'sd128, 1'b1);

    // Tens blanking edge: 9.99 degrees is blanked, 10.00 degrees is not.
    offer_reading(1'b1, 16'sd1279, 1'b0);
    offer_reading(1'b1, 16'sd1280, 1'b0);
    offer_reading(1'b1, -16'sd1280, 1'b0);

    // Extremes of the reading in both units: large magnitudes lose their
    // upper digits and negative values lose their sign.
    offer_reading(1'b1, 16'sh7FFF, 1'b0);
    offer_reading(1'b1, 16'sh7FFF, 1'b1);
    offer_reading(1'b1, -16'sh8000, 1'b0);
    offer_reading(1'b1, -16'sh8000, 1'b1);

    // Fahrenheit below zero: -40 degrees reads the same in both units.
    offer_reading(1'b1, -16'sd5120, 1'b1);
    offer_reading(1'b1, -16'sd5120, 1'b0);

    // Failed reads after good ones repeat the last display, unit included.
    offer_reading(1'b1, 16'sd3200, 1'b1);
    offer_reading(1'b0, 16'sd0, 1'b0);
    offer_reading(1'b0, -16'sh8000, 1'b0);
    offer_reading(1'b1, 16'sh5555, 1'b0);
    offer_reading(1'b1, -16'sh5556, 1'b1);

    offer_random_readings(230);

    // Long receiver hold-off while the sender keeps offering back to back,
    // so that both stages fill and the input side stalls.
    no_idling    = 1'b1;
    hold_request = 1'b1;
    offer_random_readings(30);
    no_idling = 1'b0;
    pause_until_drained();

    // A stretch with no idling on either side.
    no_idling = 1'b1;
    offer_random_readings(150);
    no_idling = 1'b0;

    offer_random_readings(318);

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
